// ===== hw/rtl/gwch_pkg.sv =====
// Package for the gift-wrap convex hull block.
// Holds the input and result item types and the fixed datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package gwch_pkg;

    localparam int COORD_BITS      = 16;
    localparam int HULL_INDEX_BITS = 6;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int PROD_BITS       = 2 * DIFF_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } point_item_t;

    typedef struct packed {
        logic [HULL_INDEX_BITS-1:0]   hull_index;
        logic signed [COORD_BITS-1:0] hull_x;
        logic signed [COORD_BITS-1:0] hull_y;
        logic                         last_of_hull;
        logic                         hull_overflow;
    } hull_item_t;

endpackage

// ===== hw/rtl/gift_wrap_convex_hull.sv =====
// Gift-wrap (Jarvis march) convex hull over a batch of loaded points.
// Depends on gwch_pkg for the item types and widths.
//
//   channel  | dir | ports                      | item
//   ---------+-----+----------------------------+--------------------------
//   s_       | in  | s_valid s_ready s_data     | point_item_t, one point
//   m_       | out | m_valid m_ready m_data     | hull_item_t, one vertex
//
// A non-last point is stored as it is accepted. The last point starts the walk:
// a scan of all points for the start, then per hull vertex a candidate load
// and a scan of all points (one memory read and two passes through the shared
// multiplier per scanned point), then each result is held until m_ready.
// s_ready is low from the last point until the final vertex is taken.
// Reset (aresetn, synchronous) clears the control state registers only.
`timescale 1ns / 1ps

module gift_wrap_convex_hull
    import gwch_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  point_item_t s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hull_item_t  m_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_MIN_RD  = 14'b00000000000010,
        ST_MIN_CMP = 14'b00000000000100,
        ST_CAND_RD = 14'b00000000001000,
        ST_CAND_LD = 14'b00000000010000,
        ST_SCAN_RD = 14'b00000000100000,
        ST_DIFF    = 14'b00000001000000,
        ST_MUL_A   = 14'b00000010000000,
        ST_MUL_B   = 14'b00000100000000,
        ST_CMP     = 14'b00001000000000,
        ST_CHOOSE  = 14'b00010000000000,
        ST_OUT_HL  = 14'b00100000000000,
        ST_OUT_XY  = 14'b01000000000000,
        ST_OUT     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
    logic [IDX_W-1:0]             hull_mem [MAX_POINTS];

    logic [CNT_W-1:0] point_count_reg;
    logic [CNT_W-1:0] hull_count_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] out_k_reg;
    logic [IDX_W-1:0] start_idx_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [IDX_W-1:0] cand_idx_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic [IDX_W-1:0] hl_rd_reg;
    logic             overflow_reg;

    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_BITS-1:0] min_x_reg, min_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0] cand_x_reg, cand_y_reg;
    logic signed [DIFF_BITS-1:0]  d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [PROD_BITS-1:0]  prod_a_reg, prod_b_reg;

    logic                         s_fire, m_fire;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         scan_last;
    logic                         min_take;
    logic [IDX_W-1:0]             min_idx_eff;
    logic signed [COORD_BITS-1:0] min_x_eff, min_y_eff;
    logic signed [DIFF_BITS-1:0]  mul_a, mul_b;
    logic signed [PROD_BITS-1:0]  mul_p;
    logic                         out_last;
    logic                         ccw;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign scan_last = (scan_reg == point_count_reg - CNT_W'(1));
    assign out_last  = (out_k_reg == hull_count_reg - CNT_W'(1));
    assign ccw       = (prod_a_reg < prod_b_reg);

    assign min_take    = (scan_reg == '0) || (rd_x_reg < min_x_reg);
    assign min_idx_eff = min_take ? scan_reg[IDX_W-1:0] : min_idx_reg;
    assign min_x_eff   = min_take ? rd_x_reg : min_x_reg;
    assign min_y_eff   = min_take ? rd_y_reg : min_y_reg;

    // shared multiplier: first pass (qy-py)*(rx-qx), second (qx-px)*(ry-qy)
    assign mul_a = (state_reg == ST_MUL_A) ? d1_reg : d3_reg;
    assign mul_b = (state_reg == ST_MUL_A) ? d2_reg : d4_reg;
    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = scan_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_MIN_RD, ST_SCAN_RD: begin
                rd_en = 1'b1;
            end
            ST_CAND_RD: begin
                rd_en   = 1'b1;
                rd_addr = (cur_idx_reg == '0) ? IDX_W'(1) : '0;
            end
            ST_OUT_XY: begin
                rd_en   = 1'b1;
                rd_addr = hl_rd_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_fire && s_data.last_point) state_next = ST_MIN_RD;
            ST_MIN_RD:  state_next = ST_MIN_CMP;
            ST_MIN_CMP: begin
                if (!scan_last) begin
                    state_next = ST_MIN_RD;
                end else if (point_count_reg == CNT_W'(1)) begin
                    state_next = ST_OUT_HL;
                end else begin
                    state_next = ST_CAND_RD;
                end
            end
            ST_CAND_RD: state_next = ST_CAND_LD;
            ST_CAND_LD: state_next = ST_SCAN_RD;
            ST_SCAN_RD: state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_MUL_A;
            ST_MUL_A:   state_next = ST_MUL_B;
            ST_MUL_B:   state_next = ST_CMP;
            ST_CMP:     state_next = scan_last ? ST_CHOOSE : ST_SCAN_RD;
            ST_CHOOSE: begin
                if (cand_idx_reg == start_idx_reg ||
                    hull_count_reg >= CNT_W'(MAX_POINTS)) begin
                    state_next = ST_OUT_HL;
                end else begin
                    state_next = ST_CAND_RD;
                end
            end
            ST_OUT_HL:  state_next = ST_OUT_XY;
            ST_OUT_XY:  state_next = ST_OUT;
            ST_OUT:     if (m_fire) state_next = out_last ? ST_IDLE : ST_OUT_HL;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            point_count_reg <= '0;
            hull_count_reg  <= '0;
            scan_reg        <= '0;
            out_k_reg       <= '0;
            start_idx_reg   <= '0;
            cur_idx_reg     <= '0;
            cand_idx_reg    <= '0;
            min_idx_reg     <= '0;
            overflow_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (point_count_reg < CNT_W'(MAX_POINTS)) begin
                            point_count_reg <= point_count_reg + CNT_W'(1);
                        end
                        scan_reg     <= '0;
                        overflow_reg <= 1'b0;
                    end
                end
                ST_MIN_CMP: begin
                    min_idx_reg <= min_idx_eff;
                    if (scan_last) begin
                        start_idx_reg  <= min_idx_eff;
                        cur_idx_reg    <= min_idx_eff;
                        hull_count_reg <= CNT_W'(1);
                        out_k_reg      <= '0;
                    end else begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end
                ST_CAND_RD: begin
                    cand_idx_reg <= rd_addr;
                    scan_reg     <= '0;
                end
                ST_CMP: begin
                    if (ccw) cand_idx_reg <= scan_reg[IDX_W-1:0];
                    if (!scan_last) scan_reg <= scan_reg + CNT_W'(1);
                end
                ST_CHOOSE: begin
                    if (cand_idx_reg == start_idx_reg) begin
                        out_k_reg <= '0;
                    end else if (hull_count_reg >= CNT_W'(MAX_POINTS)) begin
                        overflow_reg <= 1'b1;
                        out_k_reg    <= '0;
                    end else begin
                        hull_count_reg <= hull_count_reg + CNT_W'(1);
                        cur_idx_reg    <= cand_idx_reg;
                    end
                end
                ST_OUT: begin
                    if (m_fire) begin
                        if (out_last) begin
                            point_count_reg <= '0;
                        end else begin
                            out_k_reg <= out_k_reg + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    scan_reg <= scan_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_MIN_CMP: begin
                min_x_reg <= min_x_eff;
                min_y_reg <= min_y_eff;
                cur_x_reg <= min_x_eff;
                cur_y_reg <= min_y_eff;
            end
            ST_CAND_LD: begin
                cand_x_reg <= rd_x_reg;
                cand_y_reg <= rd_y_reg;
            end
            ST_DIFF: begin
                d1_reg <= DIFF_BITS'(rd_y_reg) - DIFF_BITS'(cur_y_reg);
                d2_reg <= DIFF_BITS'(cand_x_reg) - DIFF_BITS'(rd_x_reg);
                d3_reg <= DIFF_BITS'(rd_x_reg) - DIFF_BITS'(cur_x_reg);
                d4_reg <= DIFF_BITS'(cand_y_reg) - DIFF_BITS'(rd_y_reg);
            end
            ST_MUL_A: prod_a_reg <= mul_p;
            ST_MUL_B: prod_b_reg <= mul_p;
            ST_CMP: begin
                if (ccw) begin
                    cand_x_reg <= rd_x_reg;
                    cand_y_reg <= rd_y_reg;
                end
            end
            ST_CHOOSE: begin
                cur_x_reg <= cand_x_reg;
                cur_y_reg <= cand_y_reg;
            end
            default: begin
                d1_reg <= d1_reg;
            end
        endcase
    end

    // point and hull stores
    always_ff @(posedge aclk) begin
        if (s_fire && point_count_reg < CNT_W'(MAX_POINTS)) begin
            x_mem[point_count_reg[IDX_W-1:0]] <= s_data.point_x;
            y_mem[point_count_reg[IDX_W-1:0]] <= s_data.point_y;
        end
        if (rd_en) begin
            rd_x_reg <= x_mem[rd_addr];
            rd_y_reg <= y_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MIN_CMP && scan_last) begin
            hull_mem[0] <= min_idx_eff;
        end else if (state_reg == ST_CHOOSE && cand_idx_reg != start_idx_reg &&
                     hull_count_reg < CNT_W'(MAX_POINTS)) begin
            hull_mem[hull_count_reg[IDX_W-1:0]] <= cand_idx_reg;
        end
        if (state_reg == ST_OUT_HL) begin
            hl_rd_reg <= hull_mem[out_k_reg[IDX_W-1:0]];
        end
    end

    assign m_data.hull_index    = HULL_INDEX_BITS'(hl_rd_reg);
    assign m_data.hull_x        = rd_x_reg;
    assign m_data.hull_y        = rd_y_reg;
    assign m_data.last_of_hull  = out_last;
    assign m_data.hull_overflow = overflow_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        point_count_reg <= CNT_W'(MAX_POINTS) && hull_count_reg <= CNT_W'(MAX_POINTS))
        else $error("point or hull count beyond store size");

    a_out_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (hull_count_reg != '0 && out_k_reg < hull_count_reg))
        else $error("result index outside hull");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_data.last_of_hull) |=> (s_ready && point_count_reg == '0))
        else $error("batch not cleared after final vertex");

    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last_point) |=> !s_ready)
        else $error("last point did not start hull walk");
`endif

endmodule

// ===== sim/tb_gift_wrap_convex_hull.sv =====
// Testbench for gift_wrap_convex_hull: loads point batches, predicts each hull
// by an exact gift-wrap walk and checks every vertex item. Needs gwch_pkg and the block.
`timescale 1ns / 1ps

module tb_gift_wrap_convex_hull;
    import gwch_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int QUIET_LIMIT = 100000;
    localparam logic signed [COORD_BITS-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COORD_BITS-1:0] C_MAX = 16'sh7FFF;

    typedef enum int {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_EDGES} spread_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    point_item_t s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hull_item_t  m_data;

    gift_wrap_convex_hull #(
        .MAX_POINTS(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predictor state
    logic signed [COORD_BITS-1:0] pt_x [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] pt_y [STORE_DEPTH];
    int         pt_count = 0;
    hull_item_t hull_expect [$];

    int  mismatches   = 0;
    int  batches_done = 0;
    int  points_sent  = 0;
    int  points_lost  = 0;
    int  vertices_ok  = 0;
    int  capped_walks = 0;
    int  quiet_cycles = 0;
    int  rx_hold      = 0;
    int  rx_burst     = 0;
    bit  idle_en      = 1'b1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // exact orientation: (p, q, r) counter-clockwise when the cross term is negative
    function automatic bit turns_ccw(input int p, input int q, input int r);
        longint dyq, dxr, dxq, dyr;
        dyq = longint'(pt_y[q]) - longint'(pt_y[p]);
        dxr = longint'(pt_x[r]) - longint'(pt_x[q]);
        dxq = longint'(pt_x[q]) - longint'(pt_x[p]);
        dyr = longint'(pt_y[r]) - longint'(pt_y[q]);
        return (dyq * dxr - dxq * dyr) < 0;
    endfunction

    function automatic void predict_hull();
        int         path [STORE_DEPTH];
        int         first, cur, cand, kept;
        bit         capped;
        hull_item_t v;
        first  = 0;
        kept   = 1;
        capped = 1'b0;
        for (int i = 1; i < pt_count; i++)
            if (pt_x[i] < pt_x[first])
                first = i;
        path[0] = first;
        if (pt_count > 1) begin
            while (1) begin
                cur  = path[kept-1];
                cand = (cur == 0) ? 1 : 0;
                for (int i = 0; i < pt_count; i++)
                    if (turns_ccw(cur, i, cand))
                        cand = i;
                if (cand == first)
                    break;
                if (kept >= STORE_DEPTH) begin
                    capped = 1'b1;
                    break;
                end
                path[kept] = cand;
                kept++;
            end
        end
        for (int k = 0; k < kept; k++) begin
            v.hull_index    = HULL_INDEX_BITS'(path[k]);
            v.hull_x        = pt_x[path[k]];
            v.hull_y        = pt_y[path[k]];
            v.last_of_hull  = (k == kept - 1);
            v.hull_overflow = capped;
            hull_expect     = {hull_expect, v};
        end
        if (capped)
            capped_walks++;
        batches_done++;
        pt_count = 0;
    endfunction

    function automatic void store_point(input point_item_t item);
        if (pt_count < STORE_DEPTH) begin
            pt_x[pt_count] = item.point_x;
            pt_y[pt_count] = item.point_y;
            pt_count++;
        end else begin
            points_lost++;
        end
        points_sent++;
        if (item.last_point)
            predict_hull();
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord(input spread_t spread);
        logic signed [COORD_BITS-1:0] c;
        case (spread)
            SPREAD_CLUSTER: begin
                c = COORD_BITS'($urandom_range(0, 8));
                c = c - 16'sd4;
            end
            SPREAD_EDGES: begin
                case ($urandom_range(0, 5))
                    0:       c = C_MIN;
                    1:       c = C_MIN + 16'sd1;
                    2:       c = -16'sd1;
                    3:       c = 16'sd0;
                    4:       c = C_MAX - 16'sd1;
                    default: c = C_MAX;
                endcase
            end
            default: c = COORD_BITS'($urandom);
        endcase
        return c;
    endfunction

    task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input logic lp);
        point_item_t item;
        item.point_x    = px;
        item.point_y    = py;
        item.last_point = lp;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        store_point(item);
        if (lp) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_batch(input int count, input spread_t spread);
        for (int i = 0; i < count; i++)
            send_point(pick_coord(spread), pick_coord(spread), i == count - 1);
    endtask

    task automatic wait_drained();
        while (hull_expect.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_single_points();
        send_point(C_MIN, C_MAX, 1'b1);
        send_point(C_MAX, C_MIN, 1'b1);
    endtask

    // corners at the coordinate limits, two share the smallest x
    task automatic test_extreme_square();
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_degenerate_sets();
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd10, 16'sd10, 1'b0);
        send_point(-16'sd3, -16'sd3, 1'b1);
        send_point(16'sd100, -16'sd7, 1'b0);
        send_point(16'sd100, -16'sd7, 1'b1);
    endtask

    // twin points off the start: the walk bounces between them until capped
    task automatic test_hull_cap();
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd10, 16'sd0, 1'b1);
        wait_drained();
    endtask

    // two points beyond the store, the dropped one carrying the last flag
    task automatic test_full_store();
        send_batch(STORE_DEPTH + 2, SPREAD_WIDE);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        rx_hold = 600;
        send_batch(6, SPREAD_WIDE);
        send_batch(5, SPREAD_CLUSTER);
        wait_drained();
    endtask

    task automatic test_random_batches(input int until_points);
        int      count;
        spread_t spread;
        while (points_sent < until_points) begin
            count  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, STORE_DEPTH)
                                                 : $urandom_range(1, 12);
            if (count > until_points - points_sent)
                count = until_points - points_sent;
            spread = spread_t'($urandom_range(0, 2));
            idle_en = ($urandom_range(0, 3) != 0);
            send_batch(count, spread);
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
        idle_en = 1'b1;
    endtask

    task automatic test_closing_batches(input int until_points);
        idle_en = 1'b0;
        while (points_sent < until_points)
            send_batch($urandom_range(2, 8), spread_t'($urandom_range(0, 2)));
    endtask

    // receiver: long hold when asked, otherwise short random stalls while idle_en
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (rx_burst > 0) begin
                m_ready <= 1'b0;
                rx_burst--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_ready  <= 1'b0;
                rx_burst = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : vertex_check
        hull_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hull_expect.size() == 0) begin
                report_mismatch($sformatf("vertex item with none expected, index %0d",
                                          m_data.hull_index));
            end else begin
                want = hull_expect.pop_front();
                if (m_data.hull_index !== want.hull_index)
                    report_mismatch($sformatf("hull_index %0d, expected %0d",
                                              m_data.hull_index, want.hull_index));
                if (m_data.hull_x !== want.hull_x)
                    report_mismatch($sformatf("hull_x %0d, expected %0d",
                                              m_data.hull_x, want.hull_x));
                if (m_data.hull_y !== want.hull_y)
                    report_mismatch($sformatf("hull_y %0d, expected %0d",
                                              m_data.hull_y, want.hull_y));
                if (m_data.last_of_hull !== want.last_of_hull)
                    report_mismatch($sformatf("last_of_hull %b, expected %b",
                                              m_data.last_of_hull, want.last_of_hull));
                if (m_data.hull_overflow !== want.hull_overflow)
                    report_mismatch($sformatf("hull_overflow %b, expected %b",
                                              m_data.hull_overflow, want.hull_overflow));
                vertices_ok++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d vertices outstanding",
                     QUIET_LIMIT, hull_expect.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_points();
        test_extreme_square();
        test_degenerate_sets();
        test_hull_cap();
        test_full_store();
        test_output_backpressure();
        test_random_batches(140);
        test_closing_batches(160);
        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Ran %0d batches from %0d points (%0d dropped on a full store)",
                 batches_done, points_sent, points_lost);
        $display("Checked %0d hull vertices, %0d walks hit the vertex cap",
                 vertices_ok, capped_walks);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
